// ===== design/tmce_pkg.sv =====
// Package for the text mode console engine: screen geometry, character codes,
// opcodes, controller states and the command and status structs.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package tmce_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int POS_W  = 12;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_END   = 8'h80;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [POS_W-1:0]  HIDDEN_POS = POS_W'((ROWS + 1) * COLS);

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_SET    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SCR_UP = 3'd3,
        OP_SCR_DN = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CFG_LEFT    = 3'd0,
        CFG_TOP     = 3'd1,
        CFG_COLUMNS = 3'd2,
        CFG_ROWS    = 3'd3,
        CFG_SCROLLS = 3'd4,
        CFG_FG      = 3'd5,
        CFG_BG      = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FILL,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        LOOP_NONE,
        LOOP_INIT,
        LOOP_COPY_RD,
        LOOP_COPY_WR,
        LOOP_FILL
    } loop_op_t;

    typedef struct packed {
        logic     load;
        logic     exec;
        logic     result;
        loop_op_t loop;
    } dp_ctrl_t;

    typedef struct packed {
        op_t  op;
        logic put_scroll;
        logic copy_none;
        logic clear_empty;
        logic col_last;
        logic row_last;
        logic init_last;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [COL_W-1:0] left;
        logic [ROW_W-1:0] top;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
    } region_t;

    function automatic region_t region_eff(input logic [COL_W-1:0] l,
                                           input logic [ROW_W-1:0] t,
                                           input logic [COL_W-1:0] w,
                                           input logic [ROW_W-1:0] h);
        region_t          r;
        logic [COL_W-1:0] wmax;
        logic [ROW_W-1:0] hmax;
        r.left = (l > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : l;
        r.top  = (t > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : t;
        wmax   = COL_W'(COLS) - r.left;
        hmax   = ROW_W'(ROWS) - r.top;
        r.cols = (w == '0) ? COL_W'(1) : w;
        if (r.cols > wmax) r.cols = wmax;
        r.rows = (h == '0) ? ROW_W'(1) : h;
        if (r.rows > hmax) r.rows = hmax;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/text_mode_console_engine.sv =====
// Top level of the text mode console engine: stream ports, field packing,
// controller and datapath. Depends on tmce_pkg, tmce_ctrl and tmce_dp.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_tvalid / s_tready    s_tuser opcode, s_tdata command fields
//  m_        out        m_tvalid / m_tready    m_tdata cursor, offset, read data
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Put char, set cursor, read cell: ST_EXEC executes, then ST_FINISH registers the result.
// Scroll, or put char scrolling at the bottom: copy h-1 rows of a w by h region, fill one.
// Clear area: one fill write per cell of the w by h area, none when the area is empty.
// After reset a clearing pass writes all 2000 cells, one a cycle, with s_tready low.
// A result held in the output register stalls the next command in its result cycle,
// with s_tready low, until m_tready.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_engine
    import tmce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op [2:0]
    input  wire logic [2:0]  s_tuser,
    // char_code [7:0], col [15:8], row [21:16], show_cursor [22],
    // area_width [29:23], area_height [34:30], cell_address [45:35]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cursor_col [6:0], cursor_row [11:7], hw_cursor_offset [23:12], read_data [39:24]
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    dp_ctrl_t          ctrl;
    dp_stat_t          stat;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic [POS_W-1:0]  out_pos;
    logic [CELL_W-1:0] out_rd;

    assign cfg_ready = 1'b1;

    tmce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tmce_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl                 (ctrl),
        .stat                 (stat),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_op                (s_tuser),
        .in_char_code         (s_tdata[7:0]),
        .in_col               (s_tdata[15:8]),
        .in_row               (s_tdata[21:16]),
        .in_show_cursor       (s_tdata[22]),
        .in_area_width        (s_tdata[29:23]),
        .in_area_height       (s_tdata[34:30]),
        .in_cell_address      (s_tdata[45:35]),
        .m_tready             (m_tready),
        .m_tvalid             (m_tvalid),
        .out_cursor_col       (out_col),
        .out_cursor_row       (out_row),
        .out_hw_cursor_offset (out_pos),
        .out_read_data        (out_rd)
    );

    assign m_tdata = {out_rd, out_pos, out_row, out_col};

endmodule

`default_nettype wire

// ===== design/tmce_ctrl.sv =====
// Controller of the text mode console engine: the state machine that sequences
// commands, cell loops and the reset clearing pass. Uses tmce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmce_ctrl
    import tmce_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  dp_stat_t      stat,
    output dp_ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                ctrl.loop = LOOP_INIT;
                if (stat.init_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctrl.exec = 1'b1;
                case (stat.op)
                    OP_PUT: begin
                        if (!stat.put_scroll) state_next = ST_FINISH;
                        else if (stat.copy_none) state_next = ST_FILL;
                        else state_next = ST_COPY_RD;
                    end
                    OP_SCR_UP, OP_SCR_DN: begin
                        state_next = stat.copy_none ? ST_FILL : ST_COPY_RD;
                    end
                    OP_CLEAR: begin
                        state_next = stat.clear_empty ? ST_FINISH : ST_FILL;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_COPY_RD: begin
                ctrl.loop  = LOOP_COPY_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                ctrl.loop = LOOP_COPY_WR;
                state_next = (stat.col_last && stat.row_last) ? ST_FILL : ST_COPY_RD;
            end
            ST_FILL: begin
                ctrl.loop = LOOP_FILL;
                if (stat.col_last && stat.row_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    ctrl.result = 1'b1;
                    s_tready    = 1'b1;
                    if (s_tvalid) begin
                        ctrl.load  = 1'b1;
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tmce_dp.sv =====
// Datapath of the text mode console engine: configuration registers, cursor,
// screen memory, cell loop counters and the result register. Uses tmce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmce_dp
    import tmce_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  dp_ctrl_t               ctrl,
    output dp_stat_t               stat,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [COL_W-1:0]  cfg_data,
    input  wire logic [2:0]        in_op,
    input  wire logic [7:0]        in_char_code,
    input  wire logic [7:0]        in_col,
    input  wire logic [5:0]        in_row,
    input  wire logic              in_show_cursor,
    input  wire logic [COL_W-1:0]  in_area_width,
    input  wire logic [ROW_W-1:0]  in_area_height,
    input  wire logic [ADDR_W-1:0] in_cell_address,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [COL_W-1:0]       out_cursor_col,
    output logic [ROW_W-1:0]       out_cursor_row,
    output logic [POS_W-1:0]       out_hw_cursor_offset,
    output logic [CELL_W-1:0]      out_read_data
);

    logic [COL_W-1:0] left_reg, left_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [COL_W-1:0] cols_reg, cols_next;
    logic [ROW_W-1:0] rows_reg, rows_next;
    logic             scrolls_reg, scrolls_next;
    logic [3:0]       fg_reg, fg_next;
    logic [3:0]       bg_reg, bg_next;
    logic             home;
    region_t          eff_reg, eff_next;

    op_t               op_reg;
    logic [7:0]        char_reg;
    logic [7:0]        x_reg;
    logic [5:0]        y_reg;
    logic              show_reg;
    logic [COL_W-1:0]  aw_reg;
    logic [ROW_W-1:0]  ah_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic             shown_reg, shown_next;

    logic [COL_W-1:0] col_reg, col_start_reg, col_end_reg;
    logic [ROW_W-1:0] row_reg, row_end_reg;
    logic             dir_reg;
    logic [ROW_W-1:0] row_step, src_row;

    logic [ADDR_W-1:0] init_cnt_reg;
    logic              rd_flag_reg;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] mem_q_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic              m_tvalid_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CELL_W-1:0] out_rd_reg;

    logic [COL_W-1:0] rg_col_end, rg_col_last;
    logic [ROW_W-1:0] rg_row_end, rg_row_last;
    logic [CELL_W-1:0] blank;

    logic [COL_W-1:0] pc_col;
    logic [ROW_W-1:0] pc_row;
    logic             pc_write, pc_over;

    logic signed [9:0] xs, ax, ax_lo, ax_hi;
    logic signed [7:0] ys, ay, ay_lo, ay_hi;
    logic [COL_W-1:0]  sc_col;
    logic [ROW_W-1:0]  sc_row;

    logic [COL_W-1:0] sx, w_rem, ww, c_col0;
    logic [ROW_W-1:0] sy, h_rem, hh, c_row0;
    logic             clear_empty;
    logic [POS_W-1:0] pos;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

    always_comb begin
        left_next    = left_reg;
        top_next     = top_reg;
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        scrolls_next = scrolls_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        home         = 1'b0;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEFT:    begin left_next = cfg_data; home = 1'b1; end
                CFG_TOP:     begin top_next = cfg_data[ROW_W-1:0]; home = 1'b1; end
                CFG_COLUMNS: begin cols_next = cfg_data; home = 1'b1; end
                CFG_ROWS:    begin rows_next = cfg_data[ROW_W-1:0]; home = 1'b1; end
                CFG_SCROLLS: begin scrolls_next = cfg_data[0]; home = 1'b1; end
                CFG_FG:      fg_next = cfg_data[3:0];
                CFG_BG:      bg_next = cfg_data[3:0];
                default:     home = 1'b0;
            endcase
        end
        eff_next = region_eff(left_next, top_next, cols_next, rows_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            top_reg     <= '0;
            cols_reg    <= COL_W'(COLS);
            rows_reg    <= ROW_W'(ROWS);
            scrolls_reg <= 1'b1;
            fg_reg      <= 4'd7;
            bg_reg      <= 4'd0;
            eff_reg     <= '{left: '0, top: '0, cols: COL_W'(COLS), rows: ROW_W'(ROWS)};
        end else begin
            left_reg    <= left_next;
            top_reg     <= top_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            scrolls_reg <= scrolls_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            eff_reg     <= eff_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            op_reg   <= op_t'(in_op);
            char_reg <= in_char_code;
            x_reg    <= in_col;
            y_reg    <= in_row;
            show_reg <= in_show_cursor;
            aw_reg   <= in_area_width;
            ah_reg   <= in_area_height;
            addr_reg <= in_cell_address;
        end
    end

    assign rg_col_end  = eff_reg.left + eff_reg.cols;
    assign rg_col_last = rg_col_end - COL_W'(1);
    assign rg_row_end  = eff_reg.top + eff_reg.rows;
    assign rg_row_last = rg_row_end - ROW_W'(1);
    assign blank       = {bg_reg, fg_reg, CH_SPACE};

    always_comb begin
        pc_col   = cur_col_reg;
        pc_row   = cur_row_reg;
        pc_write = 1'b0;
        case (char_reg)
            CH_BS: begin
                if (cur_col_reg > eff_reg.left) begin
                    pc_col = cur_col_reg - COL_W'(1);
                end else if (cur_row_reg > eff_reg.top) begin
                    pc_col = rg_col_last;
                    pc_row = cur_row_reg - ROW_W'(1);
                end
            end
            CH_CR: pc_col = eff_reg.left;
            CH_LF: begin
                pc_col = eff_reg.left;
                pc_row = cur_row_reg + ROW_W'(1);
            end
            CH_TAB: begin
                pc_col = cur_col_reg + COL_W'(TAB_STOP) - (cur_col_reg % COL_W'(TAB_STOP));
            end
            default: begin
                if (char_reg >= CH_SPACE && char_reg < CH_END) begin
                    pc_write = 1'b1;
                    pc_col   = cur_col_reg + COL_W'(1);
                end
            end
        endcase
        if (pc_col >= rg_col_end) begin
            pc_col = eff_reg.left;
            pc_row = pc_row + ROW_W'(1);
        end
        pc_over = (pc_row >= rg_row_end);
        if (pc_over) pc_row = rg_row_last;
    end

    always_comb begin
        xs    = {{2{x_reg[7]}}, x_reg};
        ys    = {{2{y_reg[5]}}, y_reg};
        ax_lo = $signed({3'b000, eff_reg.left});
        ax_hi = $signed({3'b000, rg_col_last});
        ay_lo = $signed({3'b000, eff_reg.top});
        ay_hi = $signed({3'b000, rg_row_last});
        ax    = x_reg[7] ? ($signed({3'b000, rg_col_end}) + xs) : (ax_lo + xs);
        ay    = y_reg[5] ? ($signed({3'b000, rg_row_end}) + ys) : (ay_lo + ys);
        if (ax < ax_lo) sc_col = eff_reg.left;
        else if (ax > ax_hi) sc_col = rg_col_last;
        else sc_col = ax[COL_W-1:0];
        if (ay < ay_lo) sc_row = eff_reg.top;
        else if (ay > ay_hi) sc_row = rg_row_last;
        else sc_row = ay[ROW_W-1:0];
    end

    always_comb begin
        sx          = x_reg[7] ? '0 : x_reg[COL_W-1:0];
        sy          = y_reg[5] ? '0 : y_reg[ROW_W-1:0];
        clear_empty = (sx >= eff_reg.cols) || (sy >= eff_reg.rows);
        w_rem       = eff_reg.cols - sx;
        h_rem       = eff_reg.rows - sy;
        ww          = (aw_reg == '0 || aw_reg > w_rem) ? w_rem : aw_reg;
        hh          = (ah_reg == '0 || ah_reg > h_rem) ? h_rem : ah_reg;
        c_col0      = eff_reg.left + sx;
        c_row0      = eff_reg.top + sy;
    end

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        shown_next   = shown_reg;
        if (home) begin
            cur_col_next = eff_next.left;
            cur_row_next = eff_next.top;
        end else if (ctrl.exec) begin
            case (op_reg)
                OP_PUT: begin
                    cur_col_next = pc_col;
                    cur_row_next = pc_row;
                end
                OP_SET: begin
                    cur_col_next = sc_col;
                    cur_row_next = sc_row;
                    shown_next   = show_reg;
                end
                default: shown_next = shown_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            shown_reg   <= 1'b1;
        end else begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            shown_reg   <= shown_next;
        end
    end

    assign row_step = dir_reg ? (row_reg + ROW_W'(1)) : (row_reg - ROW_W'(1));
    assign src_row  = row_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            row_reg       <= '0;
            row_end_reg   <= '0;
            dir_reg       <= 1'b1;
        end else if (ctrl.exec) begin
            case (op_reg)
                OP_CLEAR: begin
                    col_reg       <= c_col0;
                    col_start_reg <= c_col0;
                    col_end_reg   <= c_col0 + ww - COL_W'(1);
                    row_reg       <= c_row0;
                    row_end_reg   <= c_row0 + hh - ROW_W'(1);
                    dir_reg       <= 1'b1;
                end
                OP_SCR_UP: begin
                    col_reg       <= eff_reg.left;
                    col_start_reg <= eff_reg.left;
                    col_end_reg   <= rg_col_last;
                    row_reg       <= rg_row_last;
                    row_end_reg   <= (eff_reg.rows == ROW_W'(1)) ? eff_reg.top
                                                                 : eff_reg.top + ROW_W'(1);
                    dir_reg       <= 1'b0;
                end
                default: begin
                    col_reg       <= eff_reg.left;
                    col_start_reg <= eff_reg.left;
                    col_end_reg   <= rg_col_last;
                    row_reg       <= eff_reg.top;
                    row_end_reg   <= (eff_reg.rows == ROW_W'(1)) ? eff_reg.top
                                                                 : rg_row_end - ROW_W'(2);
                    dir_reg       <= 1'b1;
                end
            endcase
        end else if (ctrl.loop == LOOP_COPY_WR || ctrl.loop == LOOP_FILL) begin
            if (col_reg == col_end_reg) begin
                col_reg <= col_start_reg;
                row_reg <= row_step;
                if (row_reg == row_end_reg) row_end_reg <= row_step;
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg <= '0;
        end else if (ctrl.loop == LOOP_INIT) begin
            init_cnt_reg <= init_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_flag_reg <= 1'b0;
        end else if (ctrl.exec) begin
            rd_flag_reg <= (op_reg == OP_READ) && (addr_reg < ADDR_W'(CELLS));
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr(row_reg, col_reg);
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        case (ctrl.loop)
            LOOP_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = RESET_CELL;
            end
            LOOP_COPY_RD: begin
                mem_re    = 1'b1;
                mem_raddr = cell_addr(src_row, col_reg);
            end
            LOOP_COPY_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_q_reg;
            end
            LOOP_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                if (ctrl.exec && op_reg == OP_PUT && pc_write) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(cur_row_reg, cur_col_reg);
                    mem_wdata = {bg_reg, fg_reg, char_reg};
                end
                if (ctrl.exec && op_reg == OP_READ && addr_reg < ADDR_W'(CELLS)) begin
                    mem_re = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_q_reg <= mem[mem_raddr];
    end

    assign pos = shown_reg ? (POS_W'(cur_row_reg) * POS_W'(COLS) + POS_W'(cur_col_reg))
                           : HIDDEN_POS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.result) begin
            out_col_reg <= cur_col_reg;
            out_row_reg <= cur_row_reg;
            out_pos_reg <= pos;
            out_rd_reg  <= rd_flag_reg ? mem_q_reg : '0;
        end
    end

    assign m_tvalid             = m_tvalid_reg;
    assign out_cursor_col       = out_col_reg;
    assign out_cursor_row       = out_row_reg;
    assign out_hw_cursor_offset = out_pos_reg;
    assign out_read_data        = out_rd_reg;

    always_comb begin
        stat.op          = op_reg;
        stat.put_scroll  = pc_over && scrolls_reg;
        stat.copy_none   = (eff_reg.rows == ROW_W'(1));
        stat.clear_empty = clear_empty;
        stat.col_last    = (col_reg == col_end_reg);
        stat.row_last    = (row_reg == row_end_reg);
        stat.init_last   = (init_cnt_reg == ADDR_W'(CELLS - 1));
        stat.out_busy    = m_tvalid_reg && !m_tready;
    end

endmodule

`default_nettype wire

// ===== design/tmce_checker.sv =====
// Port-level checker for the text mode console engine, bound to the top level.
// Depends on tmce_pkg for the screen geometry.
`timescale 1ns / 1ps
`default_nettype none

module tmce_checker
    import tmce_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] < COL_W'(COLS)) && (m_tdata[11:7] < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:12] == HIDDEN_POS) ||
                     (m_tdata[23:12] == POS_W'(m_tdata[11:7]) * POS_W'(COLS)
                                        + POS_W'(m_tdata[6:0])))
        else $error("hardware cursor offset does not match cursor");

    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready && !m_tvalid)
        else $error("input taken before screen clearing pass");

endmodule

bind text_mode_console_engine tmce_checker u_tmce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
